[rtl/core/qvr_pkg.sv]
// ----------------------------------------------------------------------------
// qvr_pkg - shared types for the quaternion vector rotator
// Holds the pipeline control group that travels between the stage modules.
// ----------------------------------------------------------------------------
`default_nettype none

package qvr_pkg;

   // Stage advance enable and the valid bit of the transaction entering a module.
   typedef struct packed {
      logic en;
      logic vld;
   } qvr_ctl_type;

endpackage

`default_nettype wire

[rtl/core/qvr_products.sv]
// ----------------------------------------------------------------------------
// qvr_products - first two pipeline stages
// Forms all quaternion and vector products, then the norm squared, the
// scalar term, the doubled dot product and the cross product.
// ----------------------------------------------------------------------------
`default_nettype none

module qvr_products #(
   parameter int COMP_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  qvr_pkg::qvr_ctl_type          ctl_in,
   input  logic signed [COMP_WIDTH-1:0]  quat_scalar,
   input  logic signed [COMP_WIDTH-1:0]  quat_i,
   input  logic signed [COMP_WIDTH-1:0]  quat_j,
   input  logic signed [COMP_WIDTH-1:0]  quat_k,
   input  logic signed [COMP_WIDTH-1:0]  vec_x,
   input  logic signed [COMP_WIDTH-1:0]  vec_y,
   input  logic signed [COMP_WIDTH-1:0]  vec_z,
   output logic                          vld_out,
   output logic [2*COMP_WIDTH:0]         n2_out,
   output logic signed [2*COMP_WIDTH+1:0] a_out,
   output logic signed [2*COMP_WIDTH+2:0] dot2_out,
   output logic signed [2*COMP_WIDTH:0]  cr_x_out,
   output logic signed [2*COMP_WIDTH:0]  cr_y_out,
   output logic signed [2*COMP_WIDTH:0]  cr_z_out,
   output logic signed [COMP_WIDTH:0]    w2_out,
   output logic signed [COMP_WIDTH-1:0]  u_x_out,
   output logic signed [COMP_WIDTH-1:0]  u_y_out,
   output logic signed [COMP_WIDTH-1:0]  u_z_out,
   output logic signed [COMP_WIDTH-1:0]  v_x_out,
   output logic signed [COMP_WIDTH-1:0]  v_y_out,
   output logic signed [COMP_WIDTH-1:0]  v_z_out
);
   import qvr_pkg::*;

   localparam int PW = 2 * COMP_WIDTH;
   localparam int SW = 2 * COMP_WIDTH + 2;
   localparam int DTW = 2 * COMP_WIDTH + 3;
   localparam int CW = 2 * COMP_WIDTH + 1;

   logic signed [PW-1:0] ww_ff, bb_ff, cc_ff, dd_ff, bx_ff, cy_ff, dz_ff;
   logic signed [PW-1:0] cz_ff, dy_ff, dx_ff, bz_ff, by_ff, cx_ff;
   logic signed [COMP_WIDTH-1:0] w1_ff, b1_ff, c1_ff, d1_ff, x1_ff, y1_ff, z1_ff;
   logic vld1_ff;

   logic signed [SW-1:0]  n2_sum;
   logic signed [SW-1:0]  a_in;
   logic signed [DTW-1:0] dot_sum;
   logic signed [DTW-1:0] dot2_in;
   logic signed [CW-1:0]  cr_x_in, cr_y_in, cr_z_in;
   logic signed [COMP_WIDTH:0] w2_in;

   logic [CW-1:0]         n2_ff;
   logic signed [SW-1:0]  a_ff;
   logic signed [DTW-1:0] dot2_ff;
   logic signed [CW-1:0]  cr_x_ff, cr_y_ff, cr_z_ff;
   logic signed [COMP_WIDTH:0] w2_ff;
   logic signed [COMP_WIDTH-1:0] b2_ff, c2_ff, d2_ff, x2_ff, y2_ff, z2_ff;
   logic vld2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else if (ctl_in.en) begin
         vld1_ff <= ctl_in.vld;
         vld2_ff <= vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_in.en) begin
         ww_ff <= quat_scalar * quat_scalar;
         bb_ff <= quat_i * quat_i;
         cc_ff <= quat_j * quat_j;
         dd_ff <= quat_k * quat_k;
         bx_ff <= quat_i * vec_x;
         cy_ff <= quat_j * vec_y;
         dz_ff <= quat_k * vec_z;
         cz_ff <= quat_j * vec_z;
         dy_ff <= quat_k * vec_y;
         dx_ff <= quat_k * vec_x;
         bz_ff <= quat_i * vec_z;
         by_ff <= quat_i * vec_y;
         cx_ff <= quat_j * vec_x;
         w1_ff <= quat_scalar;
         b1_ff <= quat_i;
         c1_ff <= quat_j;
         d1_ff <= quat_k;
         x1_ff <= vec_x;
         y1_ff <= vec_y;
         z1_ff <= vec_z;
      end
   end

   always_comb begin
      n2_sum  = SW'(ww_ff) + SW'(bb_ff) + SW'(cc_ff) + SW'(dd_ff);
      a_in    = SW'(ww_ff) - SW'(bb_ff) - SW'(cc_ff) - SW'(dd_ff);
      dot_sum = DTW'(bx_ff) + DTW'(cy_ff) + DTW'(dz_ff);
      dot2_in = dot_sum <<< 1;
      cr_x_in = CW'(cz_ff) - CW'(dy_ff);
      cr_y_in = CW'(dx_ff) - CW'(bz_ff);
      cr_z_in = CW'(by_ff) - CW'(cx_ff);
      w2_in   = {w1_ff, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (ctl_in.en) begin
         n2_ff   <= n2_sum[CW-1:0];
         a_ff    <= a_in;
         dot2_ff <= dot2_in;
         cr_x_ff <= cr_x_in;
         cr_y_ff <= cr_y_in;
         cr_z_ff <= cr_z_in;
         w2_ff   <= w2_in;
         b2_ff   <= b1_ff;
         c2_ff   <= c1_ff;
         d2_ff   <= d1_ff;
         x2_ff   <= x1_ff;
         y2_ff   <= y1_ff;
         z2_ff   <= z1_ff;
      end
   end

   assign vld_out  = vld2_ff;
   assign n2_out   = n2_ff;
   assign a_out    = a_ff;
   assign dot2_out = dot2_ff;
   assign cr_x_out = cr_x_ff;
   assign cr_y_out = cr_y_ff;
   assign cr_z_out = cr_z_ff;
   assign w2_out   = w2_ff;
   assign u_x_out  = b2_ff;
   assign u_y_out  = c2_ff;
   assign u_z_out  = d2_ff;
   assign v_x_out  = x2_ff;
   assign v_y_out  = y2_ff;
   assign v_z_out  = z2_ff;

endmodule

`default_nettype wire

[rtl/core/qvr_numer.sv]
// ----------------------------------------------------------------------------
// qvr_numer - third and fourth pipeline stages
// Multiplies the stage two terms into the vector basis and sums them into
// the exact numerator of each rotated component.
// ----------------------------------------------------------------------------
`default_nettype none

module qvr_numer #(
   parameter int COMP_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  qvr_pkg::qvr_ctl_type           ctl_in,
   input  logic [2*COMP_WIDTH:0]          n2_in,
   input  logic signed [2*COMP_WIDTH+1:0] a_in,
   input  logic signed [2*COMP_WIDTH+2:0] dot2_in,
   input  logic signed [2*COMP_WIDTH:0]   cr_x_in,
   input  logic signed [2*COMP_WIDTH:0]   cr_y_in,
   input  logic signed [2*COMP_WIDTH:0]   cr_z_in,
   input  logic signed [COMP_WIDTH:0]     w2_in,
   input  logic signed [COMP_WIDTH-1:0]   u_x_in,
   input  logic signed [COMP_WIDTH-1:0]   u_y_in,
   input  logic signed [COMP_WIDTH-1:0]   u_z_in,
   input  logic signed [COMP_WIDTH-1:0]   v_x_in,
   input  logic signed [COMP_WIDTH-1:0]   v_y_in,
   input  logic signed [COMP_WIDTH-1:0]   v_z_in,
   output logic                           vld_out,
   output logic [2*COMP_WIDTH:0]          den_out,
   output logic signed [3*COMP_WIDTH+4:0] num_x_out,
   output logic signed [3*COMP_WIDTH+4:0] num_y_out,
   output logic signed [3*COMP_WIDTH+4:0] num_z_out
);
   import qvr_pkg::*;

   localparam int AVW = 3 * COMP_WIDTH + 2;
   localparam int DUW = 3 * COMP_WIDTH + 3;
   localparam int NW  = 3 * COMP_WIDTH + 5;

   logic signed [AVW-1:0] av_x_ff, av_y_ff, av_z_ff;
   logic signed [DUW-1:0] du_x_ff, du_y_ff, du_z_ff;
   logic signed [AVW-1:0] wc_x_ff, wc_y_ff, wc_z_ff;
   logic [2*COMP_WIDTH:0] den3_ff, den4_ff;
   logic vld3_ff, vld4_ff;
   logic signed [NW-1:0] num_x_ff, num_y_ff, num_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
      end else if (ctl_in.en) begin
         vld3_ff <= ctl_in.vld;
         vld4_ff <= vld3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_in.en) begin
         av_x_ff  <= a_in * v_x_in;
         av_y_ff  <= a_in * v_y_in;
         av_z_ff  <= a_in * v_z_in;
         du_x_ff  <= dot2_in * u_x_in;
         du_y_ff  <= dot2_in * u_y_in;
         du_z_ff  <= dot2_in * u_z_in;
         wc_x_ff  <= w2_in * cr_x_in;
         wc_y_ff  <= w2_in * cr_y_in;
         wc_z_ff  <= w2_in * cr_z_in;
         den3_ff  <= n2_in;
         num_x_ff <= NW'(av_x_ff) + NW'(du_x_ff) + NW'(wc_x_ff);
         num_y_ff <= NW'(av_y_ff) + NW'(du_y_ff) + NW'(wc_y_ff);
         num_z_ff <= NW'(av_z_ff) + NW'(du_z_ff) + NW'(wc_z_ff);
         den4_ff  <= den3_ff;
      end
   end

   assign vld_out   = vld4_ff;
   assign den_out   = den4_ff;
   assign num_x_out = num_x_ff;
   assign num_y_out = num_y_ff;
   assign num_z_out = num_z_ff;

endmodule

`default_nettype wire

[rtl/core/qvr_div.sv]
// ----------------------------------------------------------------------------
// qvr_div - pipelined divide, round and saturate
// Takes the magnitude of each numerator, resolves one quotient bit per stage
// by restoring division against the norm squared, then rounds half away from
// zero, saturates and restores the sign.
// ----------------------------------------------------------------------------
`default_nettype none

module qvr_div #(
   parameter int COMP_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  qvr_pkg::qvr_ctl_type           ctl_in,
   input  logic [2*COMP_WIDTH:0]          den_in,
   input  logic signed [3*COMP_WIDTH+4:0] num_x_in,
   input  logic signed [3*COMP_WIDTH+4:0] num_y_in,
   input  logic signed [3*COMP_WIDTH+4:0] num_z_in,
   output logic                           vld_out,
   output logic [COMP_WIDTH-1:0]          rot_x,
   output logic [COMP_WIDTH-1:0]          rot_y,
   output logic [COMP_WIDTH-1:0]          rot_z,
   output logic                           zero_quat,
   output logic                           saturated
);
   import qvr_pkg::*;

   localparam int NW   = 3 * COMP_WIDTH + 5;
   localparam int DW   = 2 * COMP_WIDTH + 1;
   localparam int QW   = COMP_WIDTH + 1;
   localparam int RW   = COMP_WIDTH + 2;
   localparam int LAST = COMP_WIDTH + 1;
   localparam logic [RW-1:0] POS_LIM = RW'((1 << (COMP_WIDTH - 1)) - 1);
   localparam logic [RW-1:0] NEG_LIM = RW'(1 << (COMP_WIDTH - 1));
   localparam logic [COMP_WIDTH-1:0] MAX_VAL = POS_LIM[COMP_WIDTH-1:0];
   localparam logic [COMP_WIDTH-1:0] MIN_VAL = NEG_LIM[COMP_WIDTH-1:0];

   // Stage 0 holds magnitudes; stage s resolves quotient bit COMP_WIDTH+1-s.
   logic [2:0][NW-1:0] rem_ff [0:LAST];
   logic [2:0][NW-1:0] rem_in [0:LAST];
   logic [2:0][QW-1:0] q_ff   [0:LAST];
   logic [2:0][QW-1:0] q_in   [0:LAST];
   logic [2:0]         neg_ff [0:LAST];
   logic [DW-1:0]      den_ff [0:LAST];
   logic [LAST:0]      vld_ff;

   logic [2:0][NW-1:0] num_in;
   logic [2:0]         neg_in;

   logic [2:0][COMP_WIDTH-1:0] rot_in;
   logic [2:0]                 sat_in;
   logic                       zero_in;
   logic [2:0][COMP_WIDTH-1:0] rot_ff;
   logic                       zero_ff;
   logic                       sat_ff;
   logic                       vld_out_ff;

   assign num_in = {num_z_in, num_y_in, num_x_in};

   always_comb begin
      logic [NW-1:0] dsh;
      logic          ge;
      dsh = '0;
      ge  = 1'b0;
      for (int k = 0; k < 3; k++) begin
         neg_in[k]    = num_in[k][NW-1];
         rem_in[0][k] = neg_in[k] ? (NW'(0) - num_in[k]) : num_in[k];
         q_in[0][k]   = '0;
      end
      for (int s = 1; s <= LAST; s++) begin
         dsh = {{(NW - DW){1'b0}}, den_ff[s-1]} << (LAST - s);
         for (int k = 0; k < 3; k++) begin
            ge = rem_ff[s-1][k] >= dsh;
            rem_in[s][k] = ge ? (rem_ff[s-1][k] - dsh) : rem_ff[s-1][k];
            q_in[s][k]   = q_ff[s-1][k];
            q_in[s][k][LAST-s] = ge;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         vld_out_ff <= 1'b0;
      end else if (ctl_in.en) begin
         vld_ff     <= {vld_ff[LAST-1:0], ctl_in.vld};
         vld_out_ff <= vld_ff[LAST];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_in.en) begin
         rem_ff[0] <= rem_in[0];
         q_ff[0]   <= q_in[0];
         neg_ff[0] <= neg_in;
         den_ff[0] <= den_in;
         for (int s = 1; s <= LAST; s++) begin
            rem_ff[s] <= rem_in[s];
            q_ff[s]   <= q_in[s];
            neg_ff[s] <= neg_ff[s-1];
            den_ff[s] <= den_ff[s-1];
         end
         rot_ff  <= rot_in;
         zero_ff <= zero_in;
         sat_ff  <= |sat_in;
      end
   end

   // Round on twice the remainder, clip against the sign-dependent limit.
   always_comb begin
      logic [RW-1:0] qr;
      logic [RW-1:0] lim;
      logic [RW-1:0] qs;
      logic [RW-1:0] sv;
      qr  = '0;
      lim = '0;
      qs  = '0;
      sv  = '0;
      zero_in = (den_ff[LAST] == '0);
      for (int k = 0; k < 3; k++) begin
         qr = {1'b0, q_ff[LAST][k]} +
              RW'({rem_ff[LAST][k], 1'b0} >= {{(NW + 1 - DW){1'b0}}, den_ff[LAST]});
         lim = neg_ff[LAST][k] ? NEG_LIM : POS_LIM;
         sat_in[k] = (qr > lim) && !zero_in;
         qs = (qr > lim) ? lim : qr;
         sv = neg_ff[LAST][k] ? (RW'(0) - qs) : qs;
         rot_in[k] = zero_in ? '0 : sv[COMP_WIDTH-1:0];
      end
   end

   assign vld_out   = vld_out_ff;
   assign rot_x     = rot_ff[0];
   assign rot_y     = rot_ff[1];
   assign rot_z     = rot_ff[2];
   assign zero_quat = zero_ff;
   assign saturated = sat_ff;

   a_zero_clean: assert property (@(posedge clock) disable iff (reset)
      vld_out_ff && zero_ff |-> (rot_ff == '0) && !sat_ff)
      else $error("zero quaternion result is not a clean zero");

   a_sat_clipped: assert property (@(posedge clock) disable iff (reset)
      vld_out_ff && sat_ff |->
         (rot_ff[0] == MAX_VAL) || (rot_ff[0] == MIN_VAL) ||
         (rot_ff[1] == MAX_VAL) || (rot_ff[1] == MIN_VAL) ||
         (rot_ff[2] == MAX_VAL) || (rot_ff[2] == MIN_VAL))
      else $error("saturation flag without a clipped component");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !ctl_in.en |=> $stable(rot_ff) && $stable(vld_ff) && $stable(vld_out_ff))
      else $error("pipeline moved while stalled");

endmodule

`default_nettype wire

[rtl/core/quat_vector_rotate.sv]
// ----------------------------------------------------------------------------
// quat_vector_rotate - rotate a 3-D vector by a quaternion
// Streaming block computing the vector part of q * (0, v) * q^-1 with the
// true inverse, rounded half away from zero and saturated.
// ----------------------------------------------------------------------------
// Usage: each transaction on the req_ channel carries a quaternion and a
// vector, all signed fixed point of COMP_WIDTH bits. Each produces exactly
// one transaction on the rsp_ channel with the rotated vector in rsp_tdata
// and two flags in rsp_tuser: zero_quat (the quaternion was all zero, the
// vector is then zero) and saturated (a component was clipped).
// The pipeline has two product stages, two numerator stages, a magnitude
// stage, one restoring divide stage per quotient bit (COMP_WIDTH + 1 of
// them) and a round and saturate stage that is also the output register.
// The divide chain sets the depth. Throughput is one transaction per cycle
// unless the receiver stalls with a result waiting; the pipeline holds up to
// COMP_WIDTH + 7 transactions in flight.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and req_tready drops; bubbles in the pipeline still let req_tready stay
// high while rsp_tvalid is low. Reset clears every valid bit, so nothing is
// delivered until new transactions arrive; the block keeps no other state.
// ----------------------------------------------------------------------------
`default_nettype none

module quat_vector_rotate #(
   parameter int COMP_WIDTH = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // quat_scalar, quat_i, quat_j, quat_k, vec_x, vec_y, vec_z, zero fill
   input  logic [((7*COMP_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // rot_x, rot_y, rot_z, zero fill
   output logic [((3*COMP_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // zero_quat, saturated
   output logic [1:0] rsp_tuser
);
   import qvr_pkg::*;

   localparam int W      = COMP_WIDTH;
   localparam int OUT_DW = ((3 * COMP_WIDTH + 7) / 8) * 8;

   qvr_ctl_type ctl;
   logic        en;

   logic [2*W:0]          n2;
   logic signed [2*W+1:0] a_term;
   logic signed [2*W+2:0] dot2;
   logic signed [2*W:0]   cr_x, cr_y, cr_z;
   logic signed [W:0]     w2;
   logic signed [W-1:0]   u_x, u_y, u_z, v_x, v_y, v_z;
   logic                  vld_prod;

   qvr_ctl_type           ctl_num;
   logic                  vld_num;
   logic [2*W:0]          den;
   logic signed [3*W+4:0] num_x, num_y, num_z;

   qvr_ctl_type           ctl_div;
   logic                  vld_div;
   logic [W-1:0]          rot_x, rot_y, rot_z;
   logic                  zero_quat, saturated;

   // Single advance enable: everything moves unless a result is held.
   assign en         = !vld_div || rsp_tready;
   assign req_tready = en;
   assign ctl        = '{en: en, vld: req_tvalid};
   assign ctl_num    = '{en: en, vld: vld_prod};
   assign ctl_div    = '{en: en, vld: vld_num};

   qvr_products #(.COMP_WIDTH(W)) u_products (
      .clock       (clock),
      .reset       (reset),
      .ctl_in      (ctl),
      .quat_scalar (req_tdata[W-1:0]),
      .quat_i      (req_tdata[2*W-1:W]),
      .quat_j      (req_tdata[3*W-1:2*W]),
      .quat_k      (req_tdata[4*W-1:3*W]),
      .vec_x       (req_tdata[5*W-1:4*W]),
      .vec_y       (req_tdata[6*W-1:5*W]),
      .vec_z       (req_tdata[7*W-1:6*W]),
      .vld_out     (vld_prod),
      .n2_out      (n2),
      .a_out       (a_term),
      .dot2_out    (dot2),
      .cr_x_out    (cr_x),
      .cr_y_out    (cr_y),
      .cr_z_out    (cr_z),
      .w2_out      (w2),
      .u_x_out     (u_x),
      .u_y_out     (u_y),
      .u_z_out     (u_z),
      .v_x_out     (v_x),
      .v_y_out     (v_y),
      .v_z_out     (v_z)
   );

   qvr_numer #(.COMP_WIDTH(W)) u_numer (
      .clock     (clock),
      .reset     (reset),
      .ctl_in    (ctl_num),
      .n2_in     (n2),
      .a_in      (a_term),
      .dot2_in   (dot2),
      .cr_x_in   (cr_x),
      .cr_y_in   (cr_y),
      .cr_z_in   (cr_z),
      .w2_in     (w2),
      .u_x_in    (u_x),
      .u_y_in    (u_y),
      .u_z_in    (u_z),
      .v_x_in    (v_x),
      .v_y_in    (v_y),
      .v_z_in    (v_z),
      .vld_out   (vld_num),
      .den_out   (den),
      .num_x_out (num_x),
      .num_y_out (num_y),
      .num_z_out (num_z)
   );

   qvr_div #(.COMP_WIDTH(W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .ctl_in    (ctl_div),
      .den_in    (den),
      .num_x_in  (num_x),
      .num_y_in  (num_y),
      .num_z_in  (num_z),
      .vld_out   (vld_div),
      .rot_x     (rot_x),
      .rot_y     (rot_y),
      .rot_z     (rot_z),
      .zero_quat (zero_quat),
      .saturated (saturated)
   );

   assign rsp_tvalid = vld_div;
   assign rsp_tdata  = OUT_DW'({rot_z, rot_y, rot_x});
   assign rsp_tuser  = {saturated, zero_quat};

endmodule

`default_nettype wire

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench - self-checking bench for quat_vector_rotate
// Drives quaternion and vector transactions through the streaming port and
// compares each result with a bit-exact software rotation computed here.
// A short directed table comes first, then random transactions under
// several idling phases on both the sender and the receiver side.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW = 16;
   localparam int REQ_W = ((7*CW+7)/8)*8;
   localparam int RSP_W = ((3*CW+7)/8)*8;
   localparam int LATENCY = CW + 7;
   localparam logic signed [CW-1:0] MAXV = 16'sh7fff;
   localparam logic signed [CW-1:0] MINV = 16'sh8000;
   localparam logic signed [CW-1:0] ONE = 16'sh2000;

   // Phases of idling on the two sides.
   typedef enum int {PH_NONE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH} phase_type;

   // One incoming quaternion and vector.
   typedef struct {
      logic signed [CW-1:0] q[4];
      logic signed [CW-1:0] v[3];
   } rot_req_type;

   // One rotated vector with its flags.
   typedef struct {
      logic [CW-1:0] r[3];
      logic zero_quat;
      logic saturated;
   } rot_rsp_type;

   // A directed row: the request and, where known at a glance, its result.
   typedef struct {
      rot_req_type req;
      bit known;
      rot_rsp_type rsp;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic [1:0] rsp_tuser;

   rot_rsp_type rotations_due[$];
   int mismatches = 0;
   phase_type phase = PH_NONE;
   bit stim_done = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   quat_vector_rotate #(.COMP_WIDTH(CW)) DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   // Signed numerator over positive norm squared, rounded half away from zero,
   // then clipped to CW bits. Products stay well inside 128 bits.
   function automatic logic [CW-1:0] div_round_clip(input logic signed [127:0] num,
                                                    input logic signed [127:0] den,
                                                    inout logic clipped);
      logic signed [127:0] mag, quo, rem, lim;
      logic negative;
      negative = num < 0;
      mag = negative ? -num : num;
      quo = mag / den;
      rem = mag % den;
      if (2 * rem >= den) quo = quo + 1;
      lim = negative ? 128'sd32768 : 128'sd32767;
      if (quo > lim) begin
         quo = lim;
         clipped = 1'b1;
      end
      if (negative) quo = -quo;
      return quo[CW-1:0];
   endfunction

   // Vector part of q * (0, v) * q^-1 using the true inverse.
   function automatic rot_rsp_type rotate_vector(input rot_req_type t);
      rot_rsp_type o;
      logic signed [127:0] w, u[3], v[3], n2, a, dot, cr[3], num;
      logic clipped;
      clipped = 1'b0;
      w = t.q[0];
      for (int k = 0; k < 3; k++) begin
         u[k] = t.q[k+1];
         v[k] = t.v[k];
      end
      n2 = w*w + u[0]*u[0] + u[1]*u[1] + u[2]*u[2];
      o.zero_quat = 1'b0;
      if (n2 == 0) begin
         // A zero quaternion gives the zero vector and raises its own flag.
         for (int k = 0; k < 3; k++) o.r[k] = '0;
         o.zero_quat = 1'b1;
         o.saturated = 1'b0;
         return o;
      end
      a = w*w - u[0]*u[0] - u[1]*u[1] - u[2]*u[2];
      dot = 2 * (u[0]*v[0] + u[1]*v[1] + u[2]*v[2]);
      cr[0] = u[1]*v[2] - u[2]*v[1];
      cr[1] = u[2]*v[0] - u[0]*v[2];
      cr[2] = u[0]*v[1] - u[1]*v[0];
      for (int k = 0; k < 3; k++) begin
         num = a*v[k] + dot*u[k] + 2*w*cr[k];
         o.r[k] = div_round_clip(num, n2, clipped);
      end
      o.saturated = clipped;
      return o;
   endfunction

   function automatic rot_req_type make_req(input int w, b, c, d, x, y, z);
      rot_req_type t;
      t.q[0] = CW'(w); t.q[1] = CW'(b); t.q[2] = CW'(c); t.q[3] = CW'(d);
      t.v[0] = CW'(x); t.v[1] = CW'(y); t.v[2] = CW'(z);
      return t;
   endfunction

   // Random transaction: full-range vector; the quaternion is full range half
   // the time, else unit-scale, tiny or all zero, to reach rounding and clipping corners.
   function automatic rot_req_type random_req();
      rot_req_type t;
      int mode;
      mode = $urandom_range(0, 9);
      for (int k = 0; k < 4; k++) begin
         case (mode)
            0, 1: t.q[k] = CW'($urandom_range(0, 4) - 2);
            2, 3: t.q[k] = CW'($urandom_range(0, 2*8192) - 8192);
            default: t.q[k] = CW'($urandom);
         endcase
      end
      if (mode == 9) begin
         for (int k = 0; k < 4; k++) t.q[k] = '0;
      end
      for (int k = 0; k < 3; k++) t.v[k] = CW'($urandom);
      return t;
   endfunction

   task automatic report_mismatch(input string what, input logic [CW-1:0] got,
                                  input logic [CW-1:0] want);
      $display("%0t: %s got %h expected %h", $realtime, what, got, want);
      mismatches++;
   endtask

   // Sends one transaction, idling beforehand according to the phase.
   // The valid line stays high between back-to-back transactions and only
   // drops while the sender idles.
   task automatic send_rotation(input rot_req_type t, input bit known,
                                input rot_rsp_type rsp);
      logic [REQ_W-1:0] packed_req;
      packed_req = '0;
      if (phase == PH_SEND_IDLE) begin
         while ($urandom_range(0, 99) < 86) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end else if (phase == PH_BOTH) begin
         while ($urandom_range(0, 99) < 12) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      for (int k = 0; k < 4; k++) packed_req[k*CW +: CW] = t.q[k];
      for (int k = 0; k < 3; k++) packed_req[(k+4)*CW +: CW] = t.v[k];
      req_tvalid <= 1'b1;
      req_tdata <= packed_req;
      rotations_due.push_back(known ? rsp : rotate_vector(t));
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Receiver: stalls at random per phase, checks every accepted result.
   always @(posedge clock) begin
      rot_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (rotations_due.size() == 0) begin
               report_mismatch("result with nothing outstanding",
                               rsp_tdata[CW-1:0], '0);
            end else begin
               want = rotations_due.pop_front();
               for (int k = 0; k < 3; k++)
                  if (rsp_tdata[k*CW +: CW] !== want.r[k])
                     report_mismatch($sformatf("rot component %0d", k),
                                     rsp_tdata[k*CW +: CW], want.r[k]);
               if (rsp_tuser[0] !== want.zero_quat)
                  report_mismatch("zero_quat", rsp_tuser[0], want.zero_quat);
               if (rsp_tuser[1] !== want.saturated)
                  report_mismatch("saturated", rsp_tuser[1], want.saturated);
            end
         end
         if (phase == PH_RECV_STALL)
            rsp_tready <= ($urandom_range(0, 99) >= 86);
         else if (phase == PH_BOTH)
            rsp_tready <= ($urandom_range(0, 99) >= 12);
         else
            rsp_tready <= 1'b1;
      end
   end

   // Main sequence: reset, directed table, random phases, then drain.
   initial begin
      dir_row_type rows[$];
      dir_row_type row;
      rot_rsp_type none;
      none.r[0] = '0; none.r[1] = '0; none.r[2] = '0;
      none.zero_quat = 1'b0; none.saturated = 1'b0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zero quaternion with extreme vector: zero result and the flag.
      row.req = make_req(0, 0, 0, 0, MAXV, MINV, MAXV);
      row.known = 1'b1; row.rsp = none; row.rsp.zero_quat = 1'b1; rows.push_back(row);
      // Identity quaternion leaves the vector unchanged.
      row.req = make_req(ONE, 0, 0, 0, 100, -200, 300);
      row.known = 1'b1; row.rsp = none;
      row.rsp.r[0] = CW'(100); row.rsp.r[1] = CW'(-200); row.rsp.r[2] = CW'(300);
      rows.push_back(row);
      // Identity with extreme components passes them straight through.
      row.req = make_req(ONE, 0, 0, 0, MAXV, MINV, 0);
      row.rsp.r[0] = MAXV; row.rsp.r[1] = MINV; row.rsp.r[2] = '0; rows.push_back(row);
      // Non-unit scalar-only quaternion: scale cancels through the true inverse.
      row.req = make_req(MINV, 0, 0, 0, 7, -7, 1);
      row.rsp.r[0] = CW'(7); row.rsp.r[1] = CW'(-7); row.rsp.r[2] = CW'(1);
      rows.push_back(row);
      row.req = make_req(1, 0, 0, 0, MINV, MAXV, -1);
      row.rsp.r[0] = MINV; row.rsp.r[1] = MAXV; row.rsp.r[2] = CW'(-1); rows.push_back(row);
      // Remaining rows go through the predictor.
      row.known = 1'b0;
      row.req = make_req(0, ONE, 0, 0, 1000, 2000, 3000); rows.push_back(row);
      row.req = make_req(0, 0, ONE, 0, 1000, 2000, 3000); rows.push_back(row);
      row.req = make_req(0, 0, 0, ONE, 1000, 2000, 3000); rows.push_back(row);
      row.req = make_req(5793, 5793, 0, 0, 0, ONE, 0); rows.push_back(row);
      row.req = make_req(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV); rows.push_back(row);
      row.req = make_req(MINV, MINV, MINV, MINV, MINV, MINV, MINV); rows.push_back(row);
      row.req = make_req(MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV); rows.push_back(row);
      row.req = make_req(ONE, ONE, 0, 0, MAXV, MAXV, MAXV); rows.push_back(row);
      row.req = make_req(1, 1, 1, 1, MINV, MAXV, MINV); rows.push_back(row);
      row.req = make_req(-1, 0, 0, 0, -1, -1, -1); rows.push_back(row);
      row.req = make_req(0, 1, 1, 0, 1, 0, 0); rows.push_back(row);
      row.req = make_req(3, -2, 1, 4, 5, -6, 7); rows.push_back(row);
      row.req = make_req(0, 0, 0, MINV, 12345, -12345, 54); rows.push_back(row);

      foreach (rows[i]) send_rotation(rows[i].req, rows[i].known, rows[i].rsp);

      for (int p = 0; p < 4; p++) begin
         phase = phase_type'(p);
         repeat (325) send_rotation(random_req(), 1'b0, none);
      end
      req_tvalid <= 1'b0;
      phase = PH_NONE;

      while (rotations_due.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #20ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire
